// ----- rtl/hdu_pkg.sv -----
package hdu_pkg;

   // Receive FIFO, one slot always left empty
   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   localparam logic [15:0] BIT_PERIOD_RST = 16'd12500;

   // Command codes on req_func
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_SEND = 2'd1;
   localparam logic [1:0] FUNC_POP  = 2'd2;

   // Transmit phases: 0 lead-in high, 1 start, 2..9 data, 10 stop
   localparam logic [3:0] TX_START = 4'd1;
   localparam logic [3:0] TX_STOP  = 4'd10;
   // Receive phases: 0 start check, 1..8 data, 9 stop, 10 idle
   localparam logic [3:0] RX_STOP  = 4'd9;
   localparam logic [3:0] RX_IDLE  = 4'd10;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic       push;
      logic [7:0] data;
   } hdu_push_type;

   typedef struct packed {
      logic line_out;
      logic tx_busy;
      logic send_refused;
   } hdu_line_type;

   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

endpackage

// ----- rtl/hdu_fifo.sv -----
module hdu_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 pop,
   input  hdu_pkg::hdu_push_type wr,
   output logic [7:0]           rd_data,
   output logic                 rd_valid,
   output logic                 dropped
);
   import hdu_pkg::*;

   logic [7:0] mem [FIFO_DEPTH];
   ptr_type    head_ff, head_in;
   ptr_type    tail_ff, tail_in;
   logic [7:0] rd_ff;
   logic       full;
   logic       do_pop;
   logic       do_push;

   // pop is handled before push within one tick
   assign rd_valid = (head_ff != tail_ff);
   assign do_pop   = advance && pop && rd_valid;
   assign tail_in  = do_pop ? ptr_inc(tail_ff) : tail_ff;
   assign full     = (ptr_inc(head_ff) == tail_in);
   assign do_push  = advance && wr.push && !full;
   assign dropped  = wr.push && full;
   assign head_in  = do_push ? ptr_inc(head_ff) : head_ff;

   assign rd_data = rd_ff;

   // read data prefetched at the next tail, write forwarded into an empty queue
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[head_ff] <= wr.data;
      end
      if (do_push && head_ff == tail_in) begin
         rd_ff <= wr.data;
      end else begin
         rd_ff <= mem[tail_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

endmodule

// ----- rtl/hdu_core.sv -----
module hdu_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [1:0]            func,
   input  logic                  line_in,
   input  logic [7:0]            tx_data,
   input  logic [15:0]           bit_period,
   output hdu_pkg::hdu_line_type line,
   output hdu_pkg::hdu_push_type wr
);
   import hdu_pkg::*;

   logic [15:0] counter_ff, counter_in;
   logic [3:0]  tx_phase_ff, tx_phase_in;
   logic [7:0]  tx_shift_ff, tx_shift_in;
   logic        tx_run_ff, tx_run_in;
   logic [3:0]  rx_phase_ff, rx_phase_in;
   logic [7:0]  rx_shift_ff, rx_shift_in;
   logic        rx_en_ff, rx_en_in;
   logic        line_prev_ff;

   logic        send;
   logic        started;
   logic [16:0] cnt_inc;
   logic [3:0]  rx_ph;
   logic [2:0]  bit_sel;

   assign send    = (func == FUNC_SEND);
   assign started = send && !tx_run_ff;
   assign cnt_inc = {1'b0, counter_ff} + 17'd1;
   assign rx_ph   = (rx_phase_ff > RX_IDLE) ? RX_IDLE : rx_phase_ff;

   always_comb begin
      counter_in  = counter_ff;
      tx_phase_in = tx_phase_ff;
      tx_shift_in = tx_shift_ff;
      tx_run_in   = tx_run_ff;
      rx_phase_in = rx_phase_ff;
      rx_shift_in = rx_shift_ff;
      rx_en_in    = rx_en_ff;
      wr.push     = 1'b0;
      wr.data     = rx_shift_ff;
      if (started) begin
         // counter cleared, not advanced on the start tick
         tx_run_in   = 1'b1;
         rx_en_in    = 1'b0;
         tx_phase_in = '0;
         tx_shift_in = tx_data;
         counter_in  = '0;
      end else if (tx_run_ff) begin
         if (cnt_inc < {1'b0, bit_period}) begin
            counter_in = cnt_inc[15:0];
         end else begin
            counter_in = '0;
            if (tx_phase_ff >= TX_STOP) begin
               tx_phase_in = '0;
               tx_run_in   = 1'b0;
               rx_en_in    = 1'b1;
            end else begin
               tx_phase_in = tx_phase_ff + 4'd1;
            end
         end
      end else if (rx_en_ff) begin
         rx_phase_in = rx_ph;
         if (line_prev_ff && !line_in) begin
            // falling edge resyncs the bit timer
            counter_in = '0;
            if (rx_ph == RX_IDLE) begin
               rx_phase_in = '0;
            end
         end else if (cnt_inc < {1'b0, bit_period}) begin
            counter_in = cnt_inc[15:0];
         end else begin
            counter_in = '0;
         end
         if (counter_in == (bit_period >> 1) && rx_phase_in != RX_IDLE) begin
            if (rx_phase_in == '0) begin
               rx_phase_in = line_in ? RX_IDLE : 4'd1;
               rx_shift_in = '0;
            end else if (rx_phase_in < RX_STOP) begin
               rx_shift_in = {line_in, rx_shift_ff[7:1]};
               rx_phase_in = rx_phase_in + 4'd1;
            end else begin
               wr.push     = 1'b1;
               rx_phase_in = RX_IDLE;
            end
         end
      end
   end

   // wire level after this tick
   assign bit_sel = 3'(tx_phase_in - 4'd2);
   always_comb begin
      if (!tx_run_in || tx_phase_in == '0 || tx_phase_in >= TX_STOP) begin
         line.line_out = 1'b1;
      end else if (tx_phase_in == TX_START) begin
         line.line_out = 1'b0;
      end else begin
         line.line_out = tx_shift_in[bit_sel];
      end
   end
   assign line.tx_busy      = tx_run_in;
   assign line.send_refused = send && tx_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         tx_phase_ff  <= '0;
         tx_shift_ff  <= '0;
         tx_run_ff    <= 1'b0;
         rx_phase_ff  <= RX_IDLE;
         rx_shift_ff  <= '0;
         rx_en_ff     <= 1'b1;
         line_prev_ff <= 1'b1;
      end else if (advance) begin
         counter_ff   <= counter_in;
         tx_phase_ff  <= tx_phase_in;
         tx_shift_ff  <= tx_shift_in;
         tx_run_ff    <= tx_run_in;
         rx_phase_ff  <= rx_phase_in;
         rx_shift_ff  <= rx_shift_in;
         rx_en_ff     <= rx_en_in;
         line_prev_ff <= line_in;
      end
   end

endmodule

// ----- rtl/half_duplex_uart_8n1.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_func, req_line_in, req_tx_data
// rsp       out        rsp_valid/rsp_ready  rsp_line_out .. rsp_rx_dropped
// csr       in         csr_we               csr_wdata (bit_period)
//
// One tick per cycle while req_ready is high: a request is processed in the cycle of
// its transfer and its response sits in the output register in the cycle after.
// The output register is the only buffer; req_ready is high while it is empty
// or being drained, so a stalled rsp side stalls req after one response.
// Synchronous reset: bit_period 12500, receiver idle, FIFO empty. The FIFO
// storage is not cleared; only written slots are ever read.
module half_duplex_uart_8n1 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic        req_line_in,
   input  logic [7:0]  req_tx_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_line_out,
   output logic        rsp_tx_busy,
   output logic        rsp_send_refused,
   output logic [7:0]  rsp_rx_data,
   output logic        rsp_rx_valid,
   output logic        rsp_rx_dropped,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import hdu_pkg::*;

   logic [15:0]  bit_period_ff;
   logic         rsp_valid_ff;
   hdu_line_type line_ff;
   logic [7:0]   rx_data_ff;
   logic         rx_valid_ff;
   logic         dropped_ff;

   logic         xfer;
   logic         pop;
   hdu_line_type line;
   hdu_push_type wr;
   logic [7:0]   fifo_data;
   logic         fifo_valid;
   logic         fifo_dropped;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign xfer      = req_valid && req_ready;
   assign pop       = (req_func == FUNC_POP);

   hdu_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (xfer),
      .func       (req_func),
      .line_in    (req_line_in),
      .tx_data    (req_tx_data),
      .bit_period (bit_period_ff),
      .line       (line),
      .wr         (wr)
   );

   hdu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .advance  (xfer),
      .pop      (pop),
      .wr       (wr),
      .rd_data  (fifo_data),
      .rd_valid (fifo_valid),
      .dropped  (fifo_dropped)
   );

   // config register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BIT_PERIOD_RST;
      end else if (csr_we) begin
         bit_period_ff <= csr_wdata;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         line_ff     <= line;
         rx_valid_ff <= pop && fifo_valid;
         rx_data_ff  <= (pop && fifo_valid) ? fifo_data : 8'd0;
         dropped_ff  <= fifo_dropped;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_out     = line_ff.line_out;
   assign rsp_tx_busy      = line_ff.tx_busy;
   assign rsp_send_refused = line_ff.send_refused;
   assign rsp_rx_data      = rx_data_ff;
   assign rsp_rx_valid     = rx_valid_ff;
   assign rsp_rx_dropped   = dropped_ff;

endmodule

// ----- verif/half_duplex_uart_8n1_tb.sv -----
module half_duplex_uart_8n1_tb;
   import hdu_pkg::*;

   // Run limit in clock cycles.
   localparam int LIMIT_CYCLES = 200000;

   // Codes the package does not name
   localparam logic [1:0] FUNC_SPARE = 2'd3;  // unused code, acts as a plain tick
   localparam logic [3:0] TX_LEAD    = 4'd0;  // lead-in high before the start bit
   localparam logic [3:0] TX_DATA0   = 4'd2;  // first data phase, LSB
   localparam logic [3:0] RX_HUNT    = 4'd0;  // start bit check at half a bit
   localparam logic [3:0] RX_FIRST   = 4'd1;  // first data sample

   // One response transfer, field for field as on the rsp ports
   typedef struct packed {
      logic       line_out;
      logic       tx_busy;
      logic       send_refused;
      logic [7:0] rx_data;
      logic       rx_valid;
      logic       rx_dropped;
   } reply_type;

   // Tracks the UART state tick by tick and holds the responses still owed.
   class tick_ledger;
      logic [15:0] bit_period;
      logic [15:0] bit_counter;
      logic [3:0]  tx_phase;
      logic [7:0]  tx_shift;
      logic        tx_running;
      logic [3:0]  rx_phase;
      logic [7:0]  rx_shift;
      logic        rx_enabled;
      logic        line_prev;
      logic [7:0]  rx_store [FIFO_DEPTH];
      int          head;
      int          tail;
      reply_type   replies_due[$];
      int          mismatches;

      function new();
         bit_period  = BIT_PERIOD_RST;
         bit_counter = '0;
         tx_phase    = TX_LEAD;
         tx_shift    = '0;
         tx_running  = 1'b0;
         rx_phase    = RX_IDLE;
         rx_shift    = '0;
         rx_enabled  = 1'b1;
         line_prev   = 1'b1;
         head        = 0;
         tail        = 0;
         mismatches  = 0;
      endfunction

      // One accepted tick: pop, send, timer of the active side, edge history.
      function void log_tick(logic [1:0] func, logic line, logic [7:0] txd);
         reply_type   r;
         logic        launched;
         logic [16:0] next_count;
         int          next_head;
         r = '0;
         launched = 1'b0;
         if (func == FUNC_POP && head != tail) begin
            r.rx_data  = rx_store[tail];
            r.rx_valid = 1'b1;
            tail = (tail + 1) % FIFO_DEPTH;
         end
         if (func == FUNC_SEND) begin
            if (tx_running) begin
               r.send_refused = 1'b1;
            end else begin
               tx_running  = 1'b1;
               rx_enabled  = 1'b0;
               tx_phase    = TX_LEAD;
               tx_shift    = txd;
               bit_counter = '0;
               launched    = 1'b1;
            end
         end
         if (tx_running) begin
            // start tick neither advances the counter nor the phase
            if (!launched) begin
               next_count = {1'b0, bit_counter} + 17'd1;
               if (next_count < {1'b0, bit_period}) begin
                  bit_counter = next_count[15:0];
               end else begin
                  bit_counter = '0;
                  if (tx_phase >= TX_STOP) begin
                     tx_phase   = TX_LEAD;
                     tx_running = 1'b0;
                     rx_enabled = 1'b1;
                  end else begin
                     tx_phase = tx_phase + 4'd1;
                  end
               end
            end
         end else if (rx_enabled) begin
            if (rx_phase > RX_IDLE) rx_phase = RX_IDLE;
            if (line_prev && !line) begin
               bit_counter = '0;
               if (rx_phase == RX_IDLE) rx_phase = RX_HUNT;
            end else begin
               next_count  = {1'b0, bit_counter} + 17'd1;
               bit_counter = (next_count < {1'b0, bit_period}) ? next_count[15:0] : 16'd0;
            end
            if (bit_counter == (bit_period >> 1) && rx_phase != RX_IDLE) begin
               if (rx_phase == RX_HUNT) begin
                  rx_phase = line ? RX_IDLE : RX_FIRST;
                  rx_shift = '0;
               end else if (rx_phase < RX_STOP) begin
                  rx_shift = {line, rx_shift[7:1]};
                  rx_phase = rx_phase + 4'd1;
               end else begin
                  // stop bit level is ignored; one slot stays empty
                  next_head = (head + 1) % FIFO_DEPTH;
                  if (next_head == tail) begin
                     r.rx_dropped = 1'b1;
                  end else begin
                     rx_store[head] = rx_shift;
                     head = next_head;
                  end
                  rx_phase = RX_IDLE;
               end
            end
         end
         line_prev = line;
         if (!tx_running || tx_phase == TX_LEAD || tx_phase >= TX_STOP) begin
            r.line_out = 1'b1;
         end else if (tx_phase == TX_START) begin
            r.line_out = 1'b0;
         end else begin
            r.line_out = tx_shift[tx_phase - TX_DATA0];
         end
         r.tx_busy = tx_running;
         replies_due.push_back(r);
      endfunction

      function void check_field(string what, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
         end
      endfunction

      function void match_reply(reply_type got);
         reply_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: response transfer with nothing pending", $time);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         check_field("line_out", {7'd0, want.line_out}, {7'd0, got.line_out});
         check_field("tx_busy", {7'd0, want.tx_busy}, {7'd0, got.tx_busy});
         check_field("send_refused", {7'd0, want.send_refused},
                     {7'd0, got.send_refused});
         check_field("rx_data", want.rx_data, got.rx_data);
         check_field("rx_valid", {7'd0, want.rx_valid}, {7'd0, got.rx_valid});
         check_field("rx_dropped", {7'd0, want.rx_dropped}, {7'd0, got.rx_dropped});
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic        req_line_in;
   logic [7:0]  req_tx_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_line_out;
   logic        rsp_tx_busy;
   logic        rsp_send_refused;
   logic [7:0]  rsp_rx_data;
   logic        rsp_rx_valid;
   logic        rsp_rx_dropped;
   logic        csr_we;
   logic [15:0] csr_wdata;

   tick_ledger  book = new();
   logic        line_plan[$];   // wire levels still to be fed, one per tick
   bit          steady;         // no idling on either side while set
   int          hold_request;   // rsp hold-off length, handed to the rsp side
   int          hold_left;
   int unsigned cycle_count;

   half_duplex_uart_8n1 DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_line_in      (req_line_in),
      .req_tx_data      (req_tx_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_out     (rsp_line_out),
      .rsp_tx_busy      (rsp_tx_busy),
      .rsp_send_refused (rsp_send_refused),
      .rsp_rx_data      (rsp_rx_data),
      .rsp_rx_valid     (rsp_rx_valid),
      .rsp_rx_dropped   (rsp_rx_dropped),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // Response side: ready moves at the falling edge. A pending hold-off is
   // latched here and counted down cycle by cycle in this process.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = steady || ($urandom_range(99) >= 27);
      end
   end

   // Every response transfer is checked at the rising edge, before the
   // block's registers move. The run limit is checked last.
   always @(posedge clock) begin
      reply_type got;
      got = {rsp_line_out, rsp_tx_busy, rsp_send_refused, rsp_rx_data,
             rsp_rx_valid, rsp_rx_dropped};
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) book.match_reply(got);
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("half_duplex_uart_8n1 verification failed");
         $finish;
      end
   end

   // One tick on the request side. Called at a falling edge, returns at the
   // falling edge after the transfer; valid stays up for a following tick.
   task automatic offer_tick(input logic [1:0] f, input logic l, input logic [7:0] d);
      while (!steady && $urandom_range(99) < 27) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_func    = f;
      req_line_in = l;
      req_tx_data = d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.log_tick(f, l, d);
      @(negedge clock);
   endtask

   // Register write only once the block has drained: all responses back,
   // then a wait for the output register to settle.
   task automatic write_bit_period(input logic [15:0] value);
      req_valid = 1'b0;
      while (book.replies_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wdata = value;
      csr_we    = 1'b1;
      @(posedge clock);
      book.bit_period = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Queue up the next stretch of wire levels: mostly clean 8N1 frames,
   // sometimes off by a tick per bit, plus false starts and plain noise.
   // Bit length is capped so huge periods do not build huge plans.
   task automatic plan_line(input logic [15:0] bp);
      int         blen;
      int         n;
      int         pick;
      int         i;
      logic [7:0] b;
      blen = (bp < 16'd1) ? 1 : ((bp > 16'd64) ? 64 : int'(bp));
      pick = $urandom_range(99);
      if (pick < 75) begin
         b = 8'($urandom);
         n = blen;
         if ($urandom_range(9) == 0) n = $urandom_range(1) ? blen + 1 : blen - 1;
         if (n < 1) n = 1;
         repeat ($urandom_range(blen, 1)) line_plan.push_back(1'b1);
         repeat (n) line_plan.push_back(1'b0);
         for (i = 0; i < 8; i++) begin
            repeat (n) line_plan.push_back(b[i]);
         end
         repeat (n) line_plan.push_back(1'b1);
      end else if (pick < 88) begin
         // glitch low, shorter than a start bit more often than not
         repeat ($urandom_range(blen, 1)) line_plan.push_back(1'b0);
         repeat ($urandom_range(blen, 1)) line_plan.push_back(1'b1);
      end else begin
         repeat ($urandom_range(2 * blen, 1)) line_plan.push_back(1'($urandom_range(1)));
      end
   endtask

   // One setting of bit_period with a random command mix per tick.
   task automatic run_phase(input logic [15:0] bp, input int count, input int send_pct,
                            input int pop_pct, input bit calm, input int hold);
      int         pick;
      logic [1:0] f;
      write_bit_period(bp);
      steady       = calm;
      hold_request = hold;
      line_plan.delete();
      repeat (count) begin
         if (line_plan.size() == 0) plan_line(bp);
         pick = $urandom_range(99);
         if (pick < pop_pct) begin
            f = FUNC_POP;
         end else if (pick < pop_pct + send_pct) begin
            f = FUNC_SEND;
         end else if (pick < pop_pct + send_pct + 3) begin
            f = FUNC_SPARE;
         end else begin
            f = FUNC_TICK;
         end
         offer_tick(f, line_plan.pop_front(), 8'($urandom));
      end
      req_valid = 1'b0;
      steady    = 1'b0;
   endtask

   initial begin
      logic [7:0] frame;
      int         i;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FUNC_TICK;
      req_line_in  = 1'b1;
      req_tx_data  = '0;
      rsp_ready    = 1'b0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      steady       = 1'b0;
      hold_request = 0;
      hold_left    = 0;
      cycle_count  = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset period first
      offer_tick(FUNC_POP, 1'b1, 8'h00);    // pop with FIFO empty
      offer_tick(FUNC_SPARE, 1'b0, 8'hFF);  // spare code; falling edge arms rx
      offer_tick(FUNC_SEND, 1'b1, 8'hFF);   // send start, rx paused mid-hunt
      offer_tick(FUNC_SEND, 1'b0, 8'h00);   // refused, transmitter busy

      // One tick per bit: the send runs out, rx resumes with its phase kept
      write_bit_period(16'd1);
      repeat (11) offer_tick(FUNC_TICK, 1'b1, 8'h00);
      frame = 8'hA5;
      offer_tick(FUNC_TICK, 1'b0, 8'h00);
      for (i = 0; i < 8; i++) offer_tick(FUNC_TICK, frame[i], 8'h00);
      offer_tick(FUNC_POP, 1'b1, 8'h00);    // byte lands after the pop: empty
      offer_tick(FUNC_POP, 1'b1, 8'h00);    // now the byte comes out

      // Random part
      run_phase(16'd1,     850, 0,  0, 1'b0, 0);    // fill the FIFO, then drop
      run_phase(16'd3,     100, 2, 40, 1'b0, 0);    // drain
      run_phase(16'd4,     100, 2, 10, 1'b1, 0);    // no idling at all
      run_phase(16'd5,     100, 2, 10, 1'b0, 300);  // rsp held off, req backs up
      run_phase(16'd0,      40, 3, 20, 1'b0, 0);
      run_phase(16'd65535,  30, 5, 10, 1'b0, 0);
      run_phase(16'd9,      80, 1, 10, 1'b0, 0);
      run_phase(16'd2,      80, 3, 15, 1'b0, 0);

      req_valid = 1'b0;
      while (book.replies_due.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (book.mismatches == 0) begin
         $display("half_duplex_uart_8n1 verification clean");
      end else begin
         $display("half_duplex_uart_8n1 verification failed");
      end
      $finish;
   end

endmodule
